>>> hw/rtl/cgwq_pkg.sv
// Shared types and codes for the credit-gated wait queue.
`timescale 1ns / 1ps
package cgwq_pkg;

   localparam int ID_W     = 64;
   localparam int LOAD_W   = 20;
   localparam int CREDIT_W = 21;
   localparam int IVL_W    = 16;
   localparam int MODE_W   = 3;
   localparam int POS_W    = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TRY_ENTER  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOAD       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_TICK       = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL   = 1'd1;

   typedef enum logic [1:0] {
      QOP_SEARCH,
      QOP_REGISTER,
      QOP_UNREGISTER
   } q_op_type;

   typedef enum logic [2:0] {
      QS_IDLE,
      QS_SCAN_RD,
      QS_SCAN_CMP,
      QS_RESOLVE,
      QS_SHIFT_RD,
      QS_SHIFT_WR
   } q_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_RESP
   } top_state_type;

   typedef struct packed {
      logic            start;
      q_op_type        op;
      logic [ID_W-1:0] id;
   } q_cmd_type;

   typedef struct packed {
      logic done;
      logic ok;
   } q_sts_type;

endpackage

>>> hw/rtl/cgwq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cgwq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cgwq_queue.sv
// ID queue: fill count, sequential search with one shared comparator, shift-delete.
`timescale 1ns / 1ps
module cgwq_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cgwq_pkg::q_cmd_type            cmd,
   output cgwq_pkg::q_sts_type            sts,
   output logic [$clog2(QUEUE_DEPTH)-1:0] index
);
   import cgwq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

   q_state_type       state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   q_op_type          op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              found_ff, found_in;
   logic              done_ff, done_in;
   logic              ok_ff, ok_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ID_W-1:0]   wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [ID_W-1:0]   rd_data;

   logic              match;
   logic              scan_last;
   logic              shift_more;
   logic              shift_first;

   cgwq_ram #(
      .WIDTH (ID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign match       = (rd_data == id_ff);
   assign scan_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign shift_first = ((CNT_W'(idx_ff) + CNT_W'(1)) < count_ff);
   assign shift_more  = ((CNT_W'(idx_ff) + CNT_W'(2)) < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         QS_IDLE: begin
            if (cmd.start) begin
               state_in = (count_ff == '0) ? QS_RESOLVE : QS_SCAN_RD;
            end
         end
         QS_SCAN_RD: state_in = QS_SCAN_CMP;
         QS_SCAN_CMP: begin
            if (match || scan_last) begin
               state_in = QS_RESOLVE;
            end else begin
               state_in = QS_SCAN_RD;
            end
         end
         QS_RESOLVE: begin
            if (op_ff == QOP_UNREGISTER && found_ff && shift_first) begin
               state_in = QS_SHIFT_RD;
            end else begin
               state_in = QS_IDLE;
            end
         end
         QS_SHIFT_RD: state_in = QS_SHIFT_WR;
         QS_SHIFT_WR: state_in = shift_more ? QS_SHIFT_RD : QS_IDLE;
         default:     state_in = QS_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      id_in    = id_ff;
      found_in = found_ff;
      done_in  = 1'b0;
      ok_in    = ok_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = rd_data;
      rd_addr  = idx_ff;
      case (state_ff)
         QS_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               id_in    = cmd.id;
               idx_in   = '0;
               found_in = 1'b0;
            end
         end
         QS_SCAN_RD: begin
            rd_addr = idx_ff;
         end
         QS_SCAN_CMP: begin
            if (match) begin
               found_in = 1'b1;
            end else if (!scan_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         QS_RESOLVE: begin
            case (op_ff)
               QOP_REGISTER: begin
                  ok_in   = 1'b0;
                  done_in = 1'b1;
                  if (!found_ff && count_ff != FULL) begin
                     wr_en    = 1'b1;
                     wr_addr  = IDX_W'(count_ff);
                     wr_data  = id_ff;
                     count_in = count_ff + CNT_W'(1);
                     ok_in    = 1'b1;
                  end
               end
               QOP_UNREGISTER: begin
                  ok_in = found_ff;
                  if (!found_ff || !shift_first) begin
                     done_in = 1'b1;
                     if (found_ff) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               default: begin
                  ok_in   = found_ff;
                  done_in = 1'b1;
               end
            endcase
         end
         QS_SHIFT_RD: begin
            rd_addr = idx_ff + IDX_W'(1);
         end
         QS_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            idx_in  = idx_ff + IDX_W'(1);
            if (!shift_more) begin
               count_in = count_ff - CNT_W'(1);
               done_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= QS_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      idx_ff   <= idx_in;
      op_ff    <= op_in;
      id_ff    <= id_in;
      found_ff <= found_in;
      ok_ff    <= ok_in;
   end

   assign sts.done = done_ff;
   assign sts.ok   = ok_ff;
   assign index    = idx_ff;

endmodule

>>> hw/rtl/credit_gated_wait_queue.sv
// Top level: handshake, pass credit, load-request pacing and result register.
//
//  channel  dir  handshake           payload
//  req_     in   req_valid/ready     mode, user_id, reported_load, passed_users
//  rsp_     out  rsp_valid/ready     ok, position, request_sent, request_overdue
//  csr_     in   csr_we              csr_index, csr_wdata
//
// Load report, tick and unknown modes: result valid the cycle after the transfer.
// Register, unregister, query, try enter: the search reads the queue entries one at a
// time through the single RAM read port, reading and then comparing each; unregister
// then moves each later entry down one place, reading it and then writing it back.
// Reset empties the queue and clears credit, pending flag and tick counter.
// One item at a time: req_ready is low from transfer until the result is taken.
`timescale 1ns / 1ps
module credit_gated_wait_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cgwq_pkg::MODE_W-1:0]       req_mode,
   input  logic [cgwq_pkg::ID_W-1:0]         req_user_id,
   input  logic [cgwq_pkg::LOAD_W-1:0]       req_reported_load,
   input  logic [cgwq_pkg::LOAD_W-1:0]       req_passed_users,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [cgwq_pkg::POS_W-1:0]        rsp_position,
   output logic                              rsp_request_sent,
   output logic                              rsp_request_overdue,
   input  logic                              csr_we,
   input  logic [cgwq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cgwq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cgwq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   top_state_type       state_ff, state_in;
   logic [LOAD_W-1:0]   load_limit_ff;
   logic [IVL_W-1:0]    interval_ff;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic                pending_ff, pending_in;
   logic [IVL_W-1:0]    tick_count_ff, tick_count_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic                ok_ff, ok_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic                sent_ff, sent_in;
   logic                overdue_ff, overdue_in;

   q_cmd_type           q_cmd;
   q_sts_type           q_sts;
   logic [IDX_W-1:0]    q_index;

   logic                accept;
   logic                queue_mode;
   logic [CREDIT_W-1:0] used;
   logic [IVL_W-1:0]    tick_inc;

   cgwq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (q_cmd),
      .sts   (q_sts),
      .index (q_index)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign queue_mode = (req_mode == MODE_REGISTER) || (req_mode == MODE_UNREGISTER) ||
                       (req_mode == MODE_QUERY) || (req_mode == MODE_TRY_ENTER);
   assign used       = CREDIT_W'(req_reported_load) + CREDIT_W'(req_passed_users);
   assign tick_inc   = (tick_count_ff != '1) ? tick_count_ff + IVL_W'(1) : tick_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = queue_mode ? ST_WAIT : ST_RESP;
            end
         end
         ST_WAIT: begin
            if (q_sts.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // operation handling
   always_comb begin
      credit_in     = credit_ff;
      pending_in    = pending_ff;
      tick_count_in = tick_count_ff;
      mode_in       = mode_ff;
      ok_in         = ok_ff;
      position_in   = position_ff;
      sent_in       = sent_ff;
      overdue_in    = overdue_ff;
      q_cmd.start   = 1'b0;
      q_cmd.op      = QOP_SEARCH;
      q_cmd.id      = req_user_id;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in     = req_mode;
               ok_in       = 1'b0;
               position_in = '0;
               sent_in     = 1'b0;
               overdue_in  = 1'b0;
               q_cmd.start = queue_mode;
               case (req_mode)
                  MODE_REGISTER:   q_cmd.op = QOP_REGISTER;
                  MODE_UNREGISTER: q_cmd.op = QOP_UNREGISTER;
                  MODE_LOAD: begin
                     pending_in = 1'b0;
                     ok_in      = 1'b1;
                     if (CREDIT_W'(load_limit_ff) > used) begin
                        credit_in = CREDIT_W'(load_limit_ff) - used;
                     end
                  end
                  MODE_TICK: begin
                     ok_in         = 1'b1;
                     tick_count_in = tick_inc;
                     if (tick_inc >= interval_ff) begin
                        tick_count_in = '0;
                        if (pending_ff) begin
                           overdue_in = 1'b1;
                        end else begin
                           sent_in    = 1'b1;
                           pending_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WAIT: begin
            if (q_sts.done) begin
               case (mode_ff)
                  MODE_QUERY: begin
                     ok_in       = q_sts.ok;
                     position_in = q_sts.ok ? POS_W'(q_index) : '0;
                  end
                  MODE_TRY_ENTER: begin
                     if (q_sts.ok && q_index == '0 && credit_ff != '0) begin
                        ok_in     = 1'b1;
                        credit_in = credit_ff - CREDIT_W'(1);
                     end
                  end
                  default: ok_in = q_sts.ok;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_limit_ff <= '0;
         interval_ff   <= '0;
         credit_ff     <= '0;
         pending_ff    <= 1'b0;
         tick_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         credit_ff     <= credit_in;
         pending_ff    <= pending_in;
         tick_count_ff <= tick_count_in;
         if (csr_we && csr_index == CSR_LOAD_LIMIT) begin
            load_limit_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_INTERVAL) begin
            interval_ff <= csr_wdata[IVL_W-1:0];
         end
      end
      mode_ff     <= mode_in;
      ok_ff       <= ok_in;
      position_ff <= position_in;
      sent_ff     <= sent_in;
      overdue_ff  <= overdue_in;
   end

   assign rsp_valid           = (state_ff == ST_RESP);
   assign rsp_ok              = ok_ff;
   assign rsp_position        = position_ff;
   assign rsp_request_sent    = sent_ff;
   assign rsp_request_overdue = overdue_ff;

endmodule
